// ===== rtl/slfr_pkg.sv =====
// Shared types and constants for the serial link frame receiver.
// No dependencies; imported by every module of the block.
package slfr_pkg;

   // Preamble bytes
   localparam logic [7:0] PRE0 = 8'hBE;
   localparam logic [7:0] PRE1 = 8'hEF;
   localparam logic [7:0] PRE2 = 8'hED;

   // Header position of the checksum byte
   localparam logic [15:0] HDR_SUM_POS = 16'd6;

   // Configuration register indexes
   localparam logic [7:0] CSR_LOCAL_PORT     = 8'd0;
   localparam logic [7:0] CSR_LOCAL_PROTOCOL = 8'd1;
   localparam logic [7:0] CSR_MAX_BODY_LEN   = 8'd2;
   localparam logic [7:0] CSR_CRC_POLY       = 8'd3;

   // Reset values of the configuration registers
   localparam logic [15:0] MAX_BODY_LEN_RST = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_RST     = 16'h1021;

   // Result kinds
   localparam logic [1:0] KIND_BODY    = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD_CRC = 2'd2;
   localparam logic [1:0] KIND_REFUSED = 2'd3;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_PRE1 = 3'd1,
      PH_PRE2 = 3'd2,
      PH_HDR  = 3'd3,
      PH_BODY = 3'd4,
      PH_CRC  = 3'd5
   } phase_type;

   // One result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  body_byte;
      logic [7:0]  remote_port;
      logic [7:0]  remote_protocol;
      logic [7:0]  transaction_id;
      logic [15:0] body_size;
   } rsp_word_type;

   // Front to queue push
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } push_type;

endpackage

// ===== rtl/slfr_front.sv =====
// Front part: configuration registers, preamble hunt, header parse, CRC.
// Uses slfr_pkg; emits at most one result word per accepted byte.
module slfr_front
   import slfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   input  logic        csr_valid,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output push_type    push
);

   logic [7:0]  local_port_ff, local_protocol_ff;
   logic [15:0] max_body_len_ff, crc_poly_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  dest_ff, dest_in, src_ff, src_in, type_ff, type_in, xid_ff, xid_in;
   logic [15:0] size_ff, size_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] crc_ff, crc_in;
   logic        ignoring_ff, ignoring_in;

   logic [15:0] crc_upd;
   logic [15:0] cnt_inc;
   logic        is_match;
   logic        too_big;
   logic        sum_ok;

   // One byte of MSB-first CRC, eight narrow shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  b,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff     <= '0;
         local_protocol_ff <= '0;
         max_body_len_ff   <= MAX_BODY_LEN_RST;
         crc_poly_ff       <= CRC_POLY_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOCAL_PORT:     local_port_ff     <= csr_wdata[7:0];
            CSR_LOCAL_PROTOCOL: local_protocol_ff <= csr_wdata[7:0];
            CSR_MAX_BODY_LEN:   max_body_len_ff   <= csr_wdata;
            CSR_CRC_POLY:       crc_poly_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Shared decode terms
   assign crc_upd  = crc_byte((phase_ff == PH_PRE1 || phase_ff == PH_PRE2 ||
                               phase_ff == PH_HDR  || phase_ff == PH_BODY ||
                               phase_ff == PH_CRC) ? crc_ff : 16'h0000,
                              rx_byte, crc_poly_ff);
   assign cnt_inc  = cnt_ff + 16'd1;
   assign is_match = (type_ff == local_protocol_ff) && (dest_ff == local_port_ff);
   assign too_big  = is_match && (size_ff > max_body_len_ff);
   assign sum_ok   = (rx_byte == sum_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_PRE1: phase_in = (rx_byte == PRE1) ? PH_PRE2 : PH_HUNT;
            PH_PRE2: phase_in = (rx_byte == PRE2) ? PH_HDR : PH_HUNT;
            PH_HDR: begin
               if (cnt_ff < HDR_SUM_POS) begin
                  phase_in = PH_HDR;
               end else if (!sum_ok || too_big) begin
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = (size_ff == 16'd0) ? PH_CRC : PH_BODY;
               end
            end
            PH_BODY: phase_in = (cnt_inc >= size_ff) ? PH_CRC : PH_BODY;
            PH_CRC:  phase_in = (cnt_ff == 16'd0) ? PH_CRC : PH_HUNT;
            default: phase_in = (rx_byte == PRE0) ? PH_PRE1 : PH_HUNT;
         endcase
      end
   end

   // Datapath updates and result word
   always_comb begin
      cnt_in      = cnt_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      type_in     = type_ff;
      size_in     = size_ff;
      xid_in      = xid_ff;
      sum_in      = sum_ff;
      crc_in      = crc_ff;
      ignoring_in = ignoring_ff;
      push.valid  = 1'b0;
      push.word.kind            = KIND_BODY;
      push.word.body_byte       = 8'h00;
      push.word.remote_port     = src_ff;
      push.word.remote_protocol = type_ff;
      push.word.transaction_id  = xid_ff;
      push.word.body_size       = size_ff;
      if (accept) begin
         case (phase_ff)
            PH_PRE1, PH_PRE2: begin
               if ((phase_ff == PH_PRE1 && rx_byte == PRE1) ||
                   (phase_ff == PH_PRE2 && rx_byte == PRE2)) begin
                  sum_in = sum_ff + rx_byte;
                  crc_in = crc_upd;
               end
               cnt_in = 16'd0;
            end
            PH_HDR: begin
               crc_in = crc_upd;
               case (cnt_ff[2:0])
                  3'd0: dest_in = rx_byte;
                  3'd1: src_in  = rx_byte;
                  3'd2: type_in = rx_byte;
                  3'd3: size_in = {rx_byte, 8'h00};
                  3'd4: size_in = {size_ff[15:8], rx_byte};
                  3'd5: xid_in  = rx_byte;
                  default: ;
               endcase
               if (cnt_ff < HDR_SUM_POS) begin
                  sum_in = sum_ff + rx_byte;
                  cnt_in = cnt_inc;
               end else begin
                  cnt_in = 16'd0;
                  if (sum_ok) begin
                     ignoring_in = !is_match;
                     if (too_big) begin
                        push.valid     = 1'b1;
                        push.word.kind = KIND_REFUSED;
                     end
                  end
               end
            end
            PH_BODY: begin
               crc_in = crc_upd;
               cnt_in = (cnt_inc >= size_ff) ? 16'd0 : cnt_inc;
               if (!ignoring_ff) begin
                  push.valid          = 1'b1;
                  push.word.kind      = KIND_BODY;
                  push.word.body_byte = rx_byte;
               end
            end
            PH_CRC: begin
               crc_in = crc_upd;
               if (cnt_ff == 16'd0) begin
                  cnt_in = 16'd1;
               end else begin
                  cnt_in = 16'd0;
                  if (!ignoring_ff) begin
                     push.valid     = 1'b1;
                     push.word.kind = (crc_upd == 16'h0000) ? KIND_GOOD : KIND_BAD_CRC;
                  end
               end
            end
            default: begin
               cnt_in = 16'd0;
               if (rx_byte == PRE0) begin
                  sum_in = rx_byte;
                  crc_in = crc_upd;
               end
            end
         endcase
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         cnt_ff      <= '0;
         dest_ff     <= '0;
         src_ff      <= '0;
         type_ff     <= '0;
         size_ff     <= '0;
         xid_ff      <= '0;
         sum_ff      <= '0;
         crc_ff      <= '0;
         ignoring_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         dest_ff     <= dest_in;
         src_ff      <= src_in;
         type_ff     <= type_in;
         size_ff     <= size_in;
         xid_ff      <= xid_in;
         sum_ff      <= sum_in;
         crc_ff      <= crc_in;
         ignoring_ff <= ignoring_in;
      end
   end

endmodule

// ===== rtl/slfr_queue.sv =====
// Short result queue between the parser front and the output stage.
// Uses slfr_pkg for the result word type.
module slfr_queue
   import slfr_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output rsp_word_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   rsp_word_type    mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push.valid) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + PW'(1);
      end
      case ({push.valid, pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed word
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.word;
      end
   end

endmodule

// ===== rtl/slfr_back.sv =====
// Back part: output register that delivers queued result words.
// Uses slfr_pkg for the result word type.
module slfr_back
   import slfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  rsp_word_type q_head,
   input  logic         rsp_stall,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // Load when the register is empty or its word is taken
   assign pop      = q_not_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         word_ff <= q_head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/serial_link_frame_receiver.sv =====
// Serial link frame receiver: preamble hunt, header check, body stream, CRC verdict.
// A result word reaches rsp_ through the queue and then the output register.
// Throughput: one byte per cycle while req_stall is low, set by the byte-wide CRC and sum update.
// A queue of QUEUE_DEPTH words parts parser and output; req_stall rises only when it is full.
// Reset (synchronous): parser back to the hunt, queue and output emptied, registers
// to port 0, protocol 0, size limit 65535, polynomial 0x1021.
module serial_link_frame_receiver
   import slfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [7:0]  rsp_remote_port,
   output logic [7:0]  rsp_remote_protocol,
   output logic [7:0]  rsp_transaction_id,
   output logic [15:0] rsp_body_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   push_type     push;
   logic         q_full, q_not_empty, pop, accept;
   rsp_word_type q_head, rsp_word;

   // Take a byte whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign csr_ready = 1'b1;

   slfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   slfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   slfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .rsp_stall   (rsp_stall),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

   assign rsp_kind            = rsp_word.kind;
   assign rsp_body_byte       = rsp_word.body_byte;
   assign rsp_remote_port     = rsp_word.remote_port;
   assign rsp_remote_protocol = rsp_word.remote_protocol;
   assign rsp_transaction_id  = rsp_word.transaction_id;
   assign rsp_body_size       = rsp_word.body_size;

endmodule
